// ----- hw/rtl/cdsd_pkg.sv -----
`default_nettype none
package cdsd_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned NumLists = 4;

  // Section codes of the back-end sequencer
  localparam logic [2:0] SEC_IDLE   = 3'd0;
  localparam logic [2:0] SEC_HEADER = 3'd1;
  localparam logic [2:0] SEC_LIST0  = 3'd2;
  localparam logic [2:0] SEC_LIST3  = 3'd5;

  // Result kinds
  localparam logic [2:0] KIND_STATIC   = 3'd0;
  localparam logic [2:0] KIND_INSTANCE = 3'd1;
  localparam logic [2:0] KIND_DIRECT   = 3'd2;
  localparam logic [2:0] KIND_VIRTUAL  = 3'd3;
  localparam logic [2:0] KIND_HEADER   = 3'd4;

  // LEB128 constants
  localparam logic [7:0] LEB_PAYLOAD_MASK = 8'h7f;
  localparam int unsigned LEB_LAST_SHIFT  = 28;
  localparam logic [2:0] LEB_MAX_BYTES    = 3'd4;

  // One decoded value, tagged with a class restart
  typedef struct packed {
    logic              restart;
    logic [ValueW-1:0] value;
  } val_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ValueW-1:0] item_index;
    logic [ValueW-1:0] access_flags;
    logic [ValueW-1:0] code_offset;
    logic [ValueW-1:0] static_count;
    logic [ValueW-1:0] instance_count;
    logic [ValueW-1:0] direct_count;
    logic [ValueW-1:0] virtual_count;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } list_sel_t;

  // First nonempty list at or after start
  function automatic list_sel_t next_list(input logic [NumLists-1:0] nonzero,
                                          input logic [2:0] start);
    list_sel_t sel;
    sel.found = 1'b0;
    sel.idx   = 2'd0;
    for (int i = 0; i < NumLists; i++) begin
      if (!sel.found && nonzero[i] && (3'(i) >= start)) begin
        sel.found = 1'b1;
        sel.idx   = 2'(i);
      end
    end
    return sel;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/class_data_stream_decoder.sv -----
`default_nettype none
// Channel | Direction | tdata                         | tuser          | tlast
// in_     | slave     | data_byte[7:0]                | new_class      | -
// out_    | master    | index,flags,code,4 counts     | kind[2:0]      | last
//
// One byte is taken per cycle while in_tready is high, that is while the queue is not full;
// a result passes through the queue and the output register after the byte that closes it is accepted.
// The front end assembles LEB128 values and a two-entry queue carries them
// to the back-end sequencer, which rebuilds indices and fills the output register.
// Reset (rst_n low, synchronous) drops all work in flight and leaves the decoder idle.
// A stalled output holds the back end; the queue absorbs two values before in_tready drops.
module class_data_stream_decoder
  import cdsd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]   in_tuser,   // [0] new_class
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [223:0]      out_tdata,  // [31:0] item_index, [63:32] access_flags,
                                        // [95:64] code_offset, [127:96] static_count,
                                        // [159:128] instance_count,
                                        // [191:160] direct_count,
                                        // [223:192] virtual_count
  output logic [2:0]        out_tuser,  // [2:0] kind
  output logic              out_tlast
);

  logic      in_accept;
  logic      push;
  val_item_t push_item;
  logic      q_full;
  logic      q_valid;
  val_item_t q_item;
  logic      pop;
  out_item_t res;

  assign in_tready = ~q_full;
  assign in_accept = in_tvalid & in_tready;

  // Front end: assemble LEB128 values byte by byte
  cdsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_accept),
    .new_class  (in_tuser[0]),
    .data_byte  (in_tdata),
    .push       (push),
    .push_item  (push_item)
  );

  // Decoupling queue between value assembly and record sequencing
  cdsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // Back end: walk header and lists, build results
  cdsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {res.virtual_count, res.direct_count, res.instance_count,
                      res.static_count, res.code_offset, res.access_flags,
                      res.item_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

`ifndef ASSERT_OFF
  // Only header results carry counts
  a_counts_only_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != KIND_HEADER) |-> out_tdata[223:96] == '0)
    else $error("counts on a non-header result");

  // A header that ends the class has four zero counts
  a_empty_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_HEADER) && out_tlast |-> out_tdata[223:96] == '0)
    else $error("last header with nonzero counts");

  // Fields carry no code offset
  a_field_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == KIND_STATIC) || (out_tuser == KIND_INSTANCE))
    |-> out_tdata[95:64] == '0)
    else $error("code offset on a field result");

  // Back pressure on the input only with values waiting in the queue
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid)
    else $error("input stalled with an empty queue");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/cdsd_front.sv -----
`default_nettype none
module cdsd_front
  import cdsd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_valid,
  input  wire logic            new_class,
  input  wire logic [7:0]      data_byte,
  output logic                 push,
  output val_item_t            push_item
);

  logic [ValueW-1:0] acc_r, acc_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;

  logic [ValueW-1:0] acc_base;
  logic [2:0]        cnt_base;
  logic              pend_base;
  logic [ValueW-1:0] acc_new;
  logic              done;

  always_comb begin
    acc_base  = new_class ? '0 : acc_r;
    cnt_base  = new_class ? '0 : cnt_r;
    pend_base = new_class | pend_r;
    if (cnt_base >= LEB_MAX_BYTES) begin
      // fifth byte always closes the value
      acc_new = acc_base | (ValueW'(data_byte) << LEB_LAST_SHIFT);
      done    = 1'b1;
    end else begin
      acc_new = acc_base |
                (ValueW'(data_byte & LEB_PAYLOAD_MASK) << (5'(cnt_base) * 5'd7));
      done    = ~data_byte[7];
    end

    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    push     = 1'b0;
    push_item.restart = pend_base;
    push_item.value   = acc_new;
    if (byte_valid) begin
      if (done) begin
        push     = 1'b1;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        pend_nxt = 1'b0;
      end else begin
        acc_nxt  = acc_new;
        cnt_nxt  = cnt_base + 3'd1;
        pend_nxt = pend_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cdsd_fifo.sv -----
`default_nettype none
module cdsd_fifo
  import cdsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  val_item_t      push_item,
  output logic           full,
  output logic           q_valid,
  output val_item_t      q_item,
  input  wire logic      pop
);

  val_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cdsd_back.sv -----
`default_nettype none
module cdsd_back
  import cdsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  val_item_t  q_item,
  output logic       pop,
  output logic       res_valid,
  output out_item_t  res,
  input  wire logic  res_ready
);

  logic [2:0]        section_r, section_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [ValueW-1:0] counts_r [NumLists];
  logic [ValueW-1:0] counts_nxt [NumLists];
  logic [ValueW-1:0] left_r, left_nxt;
  logic [ValueW-1:0] run_r, run_nxt;
  logic [ValueW-1:0] hidx_r, hidx_nxt;
  logic [ValueW-1:0] hflags_r, hflags_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              can_adv;
  logic [2:0]        sec;
  logic [1:0]        slot;
  logic [1:0]        lst;
  logic              is_method;
  logic [NumLists-1:0] nonzero;
  logic [ValueW-1:0] hdr_counts [NumLists];
  list_sel_t         sel;
  logic              emit;
  out_item_t         item;

  assign can_adv   = ~out_valid_r | res_ready;
  assign pop       = q_valid & can_adv;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    section_nxt = section_r;
    slot_nxt    = slot_r;
    counts_nxt  = counts_r;
    left_nxt    = left_r;
    run_nxt     = run_r;
    hidx_nxt    = hidx_r;
    hflags_nxt  = hflags_r;
    emit        = 1'b0;
    item        = '0;

    sec       = q_item.restart ? SEC_HEADER : section_r;
    slot      = q_item.restart ? 2'd0 : slot_r;
    lst       = 2'(sec - SEC_LIST0);
    is_method = lst[1];

    // The incoming value is the last count only while in the header
    hdr_counts = counts_r;
    if (sec == SEC_HEADER) begin
      hdr_counts[3] = q_item.value;
    end
    for (int i = 0; i < NumLists; i++) begin
      nonzero[i] = (hdr_counts[i] != '0);
    end
    sel = next_list(nonzero, (sec == SEC_HEADER) ? 3'd0 : (3'(lst) + 3'd1));

    if (pop) begin
      section_nxt = sec;
      slot_nxt    = slot;
      if (sec == SEC_HEADER) begin
        counts_nxt[slot] = q_item.value;
        if (slot != 2'd3) begin
          slot_nxt = slot + 2'd1;
        end else begin
          emit                = 1'b1;
          item.kind           = KIND_HEADER;
          item.static_count   = hdr_counts[0];
          item.instance_count = hdr_counts[1];
          item.direct_count   = hdr_counts[2];
          item.virtual_count  = hdr_counts[3];
          item.last           = ~sel.found;
          section_nxt         = sel.found ? (SEC_LIST0 + 3'(sel.idx)) : SEC_IDLE;
          left_nxt            = sel.found ? hdr_counts[sel.idx] : '0;
          run_nxt             = '0;
          slot_nxt            = 2'd0;
        end
      end else if (sec >= SEC_LIST0 && sec <= SEC_LIST3) begin
        if (slot == 2'd0) begin
          hidx_nxt = run_r + q_item.value;
          slot_nxt = 2'd1;
        end else if (slot == 2'd1 && is_method) begin
          hflags_nxt = q_item.value;
          slot_nxt   = 2'd2;
        end else begin
          emit              = 1'b1;
          item.kind         = 3'(lst);
          item.item_index   = hidx_r;
          item.access_flags = is_method ? hflags_r : q_item.value;
          item.code_offset  = is_method ? q_item.value : '0;
          run_nxt           = hidx_r;
          slot_nxt          = 2'd0;
          left_nxt          = left_r - ValueW'(1);
          if (left_r == ValueW'(1)) begin
            // list exhausted: advance to the next nonempty one
            item.last   = ~sel.found;
            section_nxt = sel.found ? (SEC_LIST0 + 3'(sel.idx)) : SEC_IDLE;
            left_nxt    = sel.found ? counts_r[sel.idx] : '0;
            run_nxt     = '0;
          end
        end
      end
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (can_adv) begin
      out_valid_nxt = pop & emit;
    end
    if (pop && emit) begin
      out_nxt = item;
    end
  end

  always_ff @(posedge clk) begin
    counts_r <= counts_nxt;
    hidx_r   <= hidx_nxt;
    hflags_r <= hflags_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r   <= SEC_IDLE;
      slot_r      <= '0;
      left_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      section_r   <= section_nxt;
      slot_r      <= slot_nxt;
      left_r      <= left_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_class_data_stream_decoder.sv -----
`timescale 1ns / 1ps

module tb_class_data_stream_decoder;
  import cdsd_pkg::*;

  // Direct and virtual lists carry a code offset as the third value
  localparam logic [2:0] SEC_DIRECT = SEC_LIST0 + 3'd2;
  // Well above the slowest legal run: ~1200 bytes, sender gaps, receiver stalls
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_ITEMS = 950;
  localparam out_item_t NO_PIN = '0;

  // One byte for the input channel, with an optional hand-typed expectation
  typedef struct {
    bit        nc;
    bit [7:0]  b;
    bit        pin;
    out_item_t want;
  } feed_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  // Pinned expectation travels alongside the byte that closes it
  bit        cur_pin = 1'b0;
  out_item_t cur_want = '0;

  // Shadow state of the decoder
  logic [2:0]  dec_section = SEC_IDLE;
  logic [1:0]  dec_slot = '0;
  logic [2:0]  dec_nbytes = '0;
  logic [31:0] dec_acc = '0;
  logic [31:0] dec_counts [4] = '{default: '0};
  logic [31:0] dec_left = '0;
  logic [31:0] dec_run = '0;
  logic [31:0] dec_held_idx = '0;
  logic [31:0] dec_held_flags = '0;

  out_item_t pending_results [$];
  feed_t     plan [$];

  int errs = 0;
  int cycles = 0;
  int bytes_in = 0;
  int live_items = 0;
  int results_seen = 0;
  int classes_built = 0;
  int burst_left = 0;

  class_data_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Advance to the first nonempty list after 'from'; drop to idle if none is left.
  task automatic open_next_list(input logic [2:0] from, output bit found);
    found = 1'b0;
    for (int s = int'(from) + 1; s <= int'(SEC_LIST3); s++) begin
      if (!found && dec_counts[s - int'(SEC_LIST0)] != 0) begin
        found = 1'b1;
        dec_section = 3'(s);
        dec_left = dec_counts[s - int'(SEC_LIST0)];
      end
    end
    if (!found) begin
      dec_section = SEC_IDLE;
      dec_left = '0;
    end
    dec_run = '0;
    dec_slot = '0;
  endtask

  // Feed one accepted byte through the shadow decoder. live flags a byte that the
  // decoder actually consumes; got flags a byte that closes a result.
  task automatic decode_byte(input bit nc, input bit [7:0] b,
                             output bit live, output bit got, output out_item_t res);
    bit          done;
    bit          found;
    logic [31:0] value;
    live = 1'b0;
    got = 1'b0;
    res = '0;
    found = 1'b0;
    // A class start abandons whatever was in progress
    if (nc) begin
      dec_section = SEC_HEADER;
      dec_slot = '0;
      dec_nbytes = '0;
      dec_acc = '0;
    end
    if (dec_section != SEC_IDLE && dec_section <= SEC_LIST3) begin
      live = 1'b1;
      // The fifth byte always ends the value, whatever its top bit says
      if (dec_nbytes >= LEB_MAX_BYTES) begin
        dec_acc = dec_acc | (32'(b) << LEB_LAST_SHIFT);
        done = 1'b1;
      end else begin
        dec_acc = dec_acc | (32'(b & LEB_PAYLOAD_MASK) << (7 * dec_nbytes));
        done = !b[7];
      end
      if (!done) begin
        dec_nbytes++;
      end else begin
        value = dec_acc;
        dec_acc = '0;
        dec_nbytes = '0;
        if (dec_section == SEC_HEADER) begin
          dec_counts[dec_slot] = value;
          if (dec_slot < 2'd3) begin
            dec_slot++;
          end else begin
            got = 1'b1;
            res.kind = KIND_HEADER;
            res.static_count = dec_counts[0];
            res.instance_count = dec_counts[1];
            res.direct_count = dec_counts[2];
            res.virtual_count = dec_counts[3];
            // Empty lists are skipped; an all-empty class ends on its header
            open_next_list(SEC_HEADER, found);
            res.last = !found;
          end
        end else if (dec_slot == 2'd0) begin
          dec_held_idx = dec_run + value;
          dec_slot = 2'd1;
        end else if (dec_slot == 2'd1 && dec_section >= SEC_DIRECT) begin
          dec_held_flags = value;
          dec_slot = 2'd2;
        end else begin
          got = 1'b1;
          res.kind = dec_section - SEC_LIST0;
          res.item_index = dec_held_idx;
          if (dec_section >= SEC_DIRECT) begin
            res.access_flags = dec_held_flags;
            res.code_offset = value;
          end else begin
            res.access_flags = value;
          end
          dec_run = dec_held_idx;
          dec_slot = '0;
          dec_left--;
          if (dec_left == 0) begin
            open_next_list(dec_section, found);
            res.last = !found;
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errs++;
    end
  endtask

  // Sample both channels at the edge; inputs first so a same-edge result finds its entry
  always @(posedge clk) begin : scoreboard
    bit        live;
    bit        got;
    out_item_t res;
    out_item_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tuser[0], in_tdata, live, got, res);
        bytes_in++;
        if (live) live_items++;
        if (got) pending_results.push_back(cur_pin ? cur_want : res);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d index %h", out_tuser, out_tdata[31:0]);
          errs++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("item_index", want.item_index, out_tdata[31:0]);
          check_field("access_flags", want.access_flags, out_tdata[63:32]);
          check_field("code_offset", want.code_offset, out_tdata[95:64]);
          check_field("static_count", want.static_count, out_tdata[127:96]);
          check_field("instance_count", want.instance_count, out_tdata[159:128]);
          check_field("direct_count", want.direct_count, out_tdata[191:160]);
          check_field("virtual_count", want.virtual_count, out_tdata[223:192]);
          check_field("last", 32'(want.last), 32'(out_tlast));
        end
      end
    end
  end

  // Receiver: at the start of each window pick a new stall period and duty; about a quarter
  // of the windows never stall.
  int rx_tick = 0;
  int rx_period = 4;
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rx_tick % 64 == 0) begin
      rx_period = $urandom_range(2, 12);
      rx_hold = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, rx_period - 1);
    end
    out_tready <= ((rx_tick % rx_period) >= rx_hold);
    rx_tick++;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("tb_class_data_stream_decoder: done, errors");
      $finish;
    end
  end

  task automatic row(input bit nc, input bit [7:0] b, input bit pin, input out_item_t want);
    feed_t f;
    f.nc = nc;
    f.b = b;
    f.pin = pin;
    f.want = want;
    plan.push_back(f);
  endtask

  // Encode v as LEB128, sometimes padded with redundant continuation bytes up to
  // the five-byte limit; a fifth byte gets random junk in its upper nibble.
  task automatic put_leb(input logic [31:0] v);
    int    len;
    int    n;
    feed_t f;
    len = 1;
    while (len < 5 && (v >> (7 * len)) != 0) len++;
    n = ($urandom_range(3) == 0) ? $urandom_range(len, 5) : len;
    f.nc = 1'b0;
    f.pin = 1'b0;
    f.want = NO_PIN;
    for (int k = 0; k < n; k++) begin
      if (k == 4) f.b = {4'($urandom), v[31:28]};
      else f.b = {(k < n - 1), 7'(v >> (7 * k))};
      plan.push_back(f);
    end
  endtask

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(3))
      0: return $urandom_range(0, 5);
      1: return $urandom_range(1) ? 32'h7f : 32'h80;
      2: return $urandom;
      default: return 32'hffff_ffff - $urandom_range(0, 3);
    endcase
  endfunction

  // Build one class record into the plan, then maybe cut it short or trail noise
  task automatic build_class();
    logic [31:0] cnt [4];
    bit          empty;
    int          cut;
    feed_t       f;
    plan.delete();
    empty = ($urandom_range(7) == 0);
    for (int l = 0; l < 4; l++) begin
      if (empty) cnt[l] = '0;
      else if ($urandom_range(15) == 0) cnt[l] = $urandom >> $urandom_range(0, 31);
      else cnt[l] = $urandom_range(0, 3);
      put_leb(cnt[l]);
    end
    // Huge counts keep the class open; the next class start abandons it
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < 6 && k < cnt[l]; k++) begin
        put_leb(pick_delta());
        put_leb($urandom >> $urandom_range(0, 31));
        if (l >= 2) put_leb($urandom >> $urandom_range(0, 31));
      end
    end
    plan[0].nc = 1'b1;
    if ($urandom_range(7) == 0) begin
      cut = $urandom_range(1, plan.size());
      while (plan.size() > cut) void'(plan.pop_back());
    end
    if ($urandom_range(5) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        f.nc = ($urandom_range(7) == 0);
        f.b = 8'($urandom);
        f.pin = 1'b0;
        f.want = NO_PIN;
        plan.push_back(f);
      end
    end
    classes_built++;
  endtask

  // Offer one item; sender runs in bursts with random gaps, sometimes a long
  // burst with no gaps at all.
  task automatic send(input feed_t f);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= f.b;
    in_tuser <= f.nc;
    cur_pin <= f.pin;
    cur_want <= f.want;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every outstanding result has drained
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: hand-typed results where they are obvious
    plan.delete();
    // Byte while idle without a class start: dropped
    row(1'b0, 8'h55, 1'b0, NO_PIN);
    // Partial header value, abandoned by the next class start
    row(1'b1, 8'h81, 1'b0, NO_PIN);
    // Empty class: header alone, marked last
    row(1'b1, 8'h00, 1'b0, NO_PIN);
    row(1'b0, 8'h00, 1'b0, NO_PIN);
    row(1'b0, 8'h00, 1'b0, NO_PIN);
    row(1'b0, 8'h00, 1'b1, '{KIND_HEADER, 32'd0, 32'd0, 32'd0,
                             32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
    // One static field, one virtual method; the two middle lists are skipped
    row(1'b1, 8'h01, 1'b0, NO_PIN);
    row(1'b0, 8'h00, 1'b0, NO_PIN);
    row(1'b0, 8'h00, 1'b0, NO_PIN);
    row(1'b0, 8'h01, 1'b1, '{KIND_HEADER, 32'd0, 32'd0, 32'd0,
                             32'd1, 32'd0, 32'd0, 32'd1, 1'b0});
    // Static field: delta 0, flags all ones via five bytes of 0xff
    row(1'b0, 8'h00, 1'b0, NO_PIN);
    repeat (4) row(1'b0, 8'hff, 1'b0, NO_PIN);
    row(1'b0, 8'hff, 1'b1, '{KIND_STATIC, 32'd0, 32'hffff_ffff, 32'd0,
                             32'd0, 32'd0, 32'd0, 32'd0, 1'b0});
    // Virtual method: zero flags, padded code from a fifth byte with its top bit set
    row(1'b0, 8'h7f, 1'b0, NO_PIN);
    row(1'b0, 8'h00, 1'b0, NO_PIN);
    repeat (4) row(1'b0, 8'h80, 1'b0, NO_PIN);
    row(1'b0, 8'h8f, 1'b1, '{KIND_VIRTUAL, 32'h7f, 32'd0, 32'hf000_0000,
                             32'd0, 32'd0, 32'd0, 32'd0, 1'b1});
    foreach (plan[i]) send(plan[i]);
    settle();

    // Random classes, checked against the shadow decoder
    while (live_items < TARGET_ITEMS) begin
      build_class();
      foreach (plan[i]) send(plan[i]);
      if ($urandom_range(15) == 0) settle();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("fed %0d bytes (%0d decoded) over %0d random classes plus directed rows",
             bytes_in, live_items, classes_built);
    $display("compared %0d results, %0d mismatches", results_seen, errs);
    if (errs == 0 && pending_results.size() == 0) begin
      $display("tb_class_data_stream_decoder: done, clean");
    end else begin
      $display("tb_class_data_stream_decoder: done, errors");
    end
    $finish;
  end

endmodule
